// ----- rtl/core/comment_and_space_stripper_macros.svh -----
// Assertion macros shared by the checker of the comment and space stripper.
`ifndef COMMENT_AND_SPACE_STRIPPER_MACROS_SVH
`define COMMENT_AND_SPACE_STRIPPER_MACROS_SVH

// Property checked on every rising edge outside reset.
`define CSS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Property checked on every rising edge, reset included.
`define CSS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ----- rtl/core/css_pkg.sv -----
// Types and constants shared by the comment and space stripper modules.
package css_pkg;

  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_SLASH  = 3'd1,
    ST_STRING = 3'd2,
    ST_LINE   = 3'd3,
    ST_BLOCK  = 3'd4,
    ST_BSTAR  = 3'd5
  } scan_state_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int QUEUE_DEPTH = 4;

  // Work left by one input byte: up to two kept bytes and the end-of-stream mark.
  typedef struct packed {
    logic       last;
    logic [7:0] byte1;
    logic [7:0] byte0;
    logic [1:0] cnt;
  } action_t;

endpackage

// ----- rtl/core/css_front.sv -----
// Front end: accepts text bytes, runs the comment scanner and queues the kept bytes.
module css_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  logic               s_axis_tlast,
  input  logic               q_full,
  output logic               push,
  output css_pkg::action_t   push_data
);

  css_pkg::scan_state_t state, state_next;
  logic                 strip;
  logic                 accept;
  logic                 pre_slash, main_v, tail_slash;
  logic                 is_ws;
  logic [1:0]           cnt;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_ws = (s_axis_tdata == css_pkg::CH_SPACE) || (s_axis_tdata == css_pkg::CH_NL);

  always_ff @(posedge clk) begin
    if (rst) begin
      strip <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      strip <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= css_pkg::ST_NORMAL;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_comb begin
    pre_slash  = 1'b0;
    main_v     = 1'b0;
    tail_slash = 1'b0;
    state_next = state;
    unique case (state)
      css_pkg::ST_SLASH: begin
        if (s_axis_tdata == css_pkg::CH_SLASH) begin
          state_next = css_pkg::ST_LINE;
        end else if (s_axis_tdata == css_pkg::CH_STAR) begin
          state_next = css_pkg::ST_BLOCK;
        end else begin
          // The lone slash is kept, then the byte is scanned as normal text.
          pre_slash = 1'b1;
          if (s_axis_tdata == css_pkg::CH_QUOTE) begin
            main_v     = 1'b1;
            state_next = css_pkg::ST_STRING;
          end else begin
            main_v     = !(strip && is_ws);
            state_next = css_pkg::ST_NORMAL;
          end
        end
      end
      css_pkg::ST_STRING: begin
        main_v = 1'b1;
        if (s_axis_tdata == css_pkg::CH_QUOTE) begin
          state_next = css_pkg::ST_NORMAL;
        end
      end
      css_pkg::ST_LINE: begin
        if (s_axis_tdata == css_pkg::CH_NL) begin
          main_v     = !strip;
          state_next = css_pkg::ST_NORMAL;
        end
      end
      css_pkg::ST_BLOCK: begin
        if (s_axis_tdata == css_pkg::CH_STAR) begin
          state_next = css_pkg::ST_BSTAR;
        end
      end
      css_pkg::ST_BSTAR: begin
        if (s_axis_tdata == css_pkg::CH_SLASH) begin
          state_next = css_pkg::ST_NORMAL;
        end else if (s_axis_tdata != css_pkg::CH_STAR) begin
          state_next = css_pkg::ST_BLOCK;
        end
      end
      default: begin
        if (s_axis_tdata == css_pkg::CH_QUOTE) begin
          main_v     = 1'b1;
          state_next = css_pkg::ST_STRING;
        end else if (s_axis_tdata == css_pkg::CH_SLASH) begin
          state_next = css_pkg::ST_SLASH;
        end else begin
          main_v     = !(strip && is_ws);
          state_next = css_pkg::ST_NORMAL;
        end
      end
    endcase
    if (s_axis_tlast) begin
      tail_slash = (state_next == css_pkg::ST_SLASH);
      state_next = css_pkg::ST_NORMAL;
    end
  end

  // At most two of the three sources are set, and a trailing slash never joins the byte itself.
  assign cnt = 2'({1'b0, pre_slash} + {1'b0, main_v} + {1'b0, tail_slash});

  always_comb begin
    push_data.cnt   = cnt;
    push_data.last  = s_axis_tlast;
    push_data.byte0 = pre_slash ? css_pkg::CH_SLASH
                    : (main_v ? s_axis_tdata : css_pkg::CH_SLASH);
    push_data.byte1 = main_v ? s_axis_tdata : css_pkg::CH_SLASH;
  end

  assign push = accept && ((cnt != 2'd0) || s_axis_tlast);

endmodule

// ----- rtl/core/css_queue.sv -----
// Short queue of scanner actions between the front and back ends.
module css_queue #(
  parameter int Depth = css_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  css_pkg::action_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output css_pkg::action_t q_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  css_pkg::action_t mem [Depth];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign full    = (count == CW'(Depth));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/css_back.sv -----
// Back end: turns queued actions into output words, one word per cycle while the receiver takes them.
module css_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  css_pkg::action_t q_data,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  logic half;
  logic load;
  logic two_first;

  assign load      = !m_axis_tvalid || m_axis_tready;
  assign two_first = (q_data.cnt == 2'd2) && !half;
  assign pop       = load && q_valid && !two_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      half          <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= q_valid;
      if (q_valid) begin
        half <= two_first;
      end
    end
  end

  // tuser[0] is has_byte, tuser[1] is run_end.
  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      case (q_data.cnt)
        2'd0: begin
          m_axis_tdata <= '0;
          m_axis_tuser <= 2'b10;
          m_axis_tlast <= 1'b1;
        end
        2'd2: begin
          m_axis_tdata <= half ? q_data.byte1 : q_data.byte0;
          m_axis_tuser <= {half, 1'b1};
          m_axis_tlast <= half && q_data.last;
        end
        default: begin
          m_axis_tdata <= q_data.byte0;
          m_axis_tuser <= 2'b11;
          m_axis_tlast <= q_data.last;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/comment_and_space_stripper.sv -----
// Top level of the C comment and whitespace stripper.
// The block takes one text byte per cycle while the action queue has room, drops
// line and block comments, passes string literals untouched and deletes spaces
// and newlines outside strings when strip_whitespace is set. A byte passes
// through the scanner in the cycle it is accepted, and its first kept byte is
// written into the action queue and then into the output register. The output
// gives one word per cycle while the receiver takes it; a byte that keeps two
// bytes (a lone slash with the byte that follows it) needs two output words,
// while a slash flushed at stream end always travels alone in one word. The
// sustained rate is one byte per cycle except at such pairs or receiver stalls,
// which the queue (QueueDepth entries) absorbs before the input is held off.
module comment_and_space_stripper #(
  parameter int QueueDepth = css_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,       // strip_whitespace
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic [1:0] m_axis_tuser,   // [0] has_byte, [1] run_end
  output logic       m_axis_tlast    // stream_end
);

  logic             push, q_full, pop, q_valid;
  css_pkg::action_t push_data, q_data;

  css_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  css_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  css_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- rtl/core/css_checker.sv -----
// Port-level checks for the comment and space stripper, bound to the top level.
`include "comment_and_space_stripper_macros.svh"

module css_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // No output word is shown in the cycle after reset.
  `CSS_ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !m_axis_tvalid)

  // A stalled word keeps its contents.
  `CSS_ASSERT(a_hold_on_stall, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // The end of the stream is also the end of the byte's results.
  `CSS_ASSERT(a_stream_end_ends_run, clk, rst,
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])

  // An empty word only marks the end of the stream and carries zero.
  `CSS_ASSERT(a_empty_is_end_marker, clk, rst,
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))

endmodule

bind comment_and_space_stripper css_checker u_css_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
